// File: hdl/lkcd_pkg.sv
// Shared types and constants for the LRU key cache directory.
// No dependencies.
package lkcd_pkg;
    localparam int ENTRIES = 32;
    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_W = 6;
    localparam int KEY_W = 64;

    typedef enum logic [1:0] {
        KIND_BYPASS = 2'd0,
        KIND_HIT    = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_EVICT  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_INSERT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request key
        logic lookup;    // register hit result and hit slot
        logic touch;     // make hit slot most recent
        logic evict;     // drop victim slot
        logic insert;    // write key into free slot
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic            hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [SLOT_W-1:0] victim_slot;
        logic [SLOT_W-1:0] free_slot;
        logic            must_evict;
        logic            cap_zero;
    } status_t;
endpackage

// File: hdl/lkcd_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on lkcd_pkg.
interface lkcd_req_if;
    logic valid;
    logic ready;
    logic [lkcd_pkg::KEY_W-1:0] key_word0;
    logic [lkcd_pkg::KEY_W-1:0] key_word1;
    logic [lkcd_pkg::KEY_W-1:0] key_word2;
    logic [lkcd_pkg::KEY_W-1:0] key_word3;
    logic bypass;
    modport source (output valid, key_word0, key_word1, key_word2, key_word3, bypass,
                    input ready);
    modport sink (input valid, key_word0, key_word1, key_word2, key_word3, bypass,
                  output ready);
endinterface

interface lkcd_res_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [4:0] slot;
    logic last;
    modport source (output valid, kind, slot, last, input ready);
    modport sink (input valid, kind, slot, last, output ready);
endinterface

interface lkcd_cfg_if;
    logic valid;
    logic ready;
    logic [lkcd_pkg::CAP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: hdl/lkcd_datapath.sv
// Directory storage: tags, valid bits, recency ranks, count and capacity.
// Depends on lkcd_pkg.
module lkcd_datapath (
    input  logic clk,
    input  logic rst_n,
    input  lkcd_pkg::cmd_t cmd,
    input  logic [lkcd_pkg::KEY_W*4-1:0] key_in,
    input  logic cfg_we,
    input  logic [lkcd_pkg::CAP_W-1:0] cfg_data,
    output lkcd_pkg::status_t status
);
    localparam int N = lkcd_pkg::ENTRIES;
    localparam int SW = lkcd_pkg::SLOT_W;
    localparam int CW = lkcd_pkg::CNT_W;

    logic [lkcd_pkg::KEY_W*4-1:0] key_reg;
    logic [lkcd_pkg::KEY_W*4-1:0] tag_reg [N];
    logic [N-1:0] valid_reg;
    logic [SW-1:0] rank_reg [N];
    logic [CW-1:0] count_reg;
    logic [lkcd_pkg::CAP_W-1:0] cap_reg;
    logic hit_reg;
    logic [SW-1:0] hit_slot_reg, victim_reg, free_reg;

    logic [N-1:0] match_c;
    logic [SW-1:0] hit_c, victim_c, free_c;
    logic [lkcd_pkg::CAP_W-1:0] cap_eff;
    logic [SW-1:0] old_rank;
    logic [SW-1:0] oldest;

    always_comb
    begin
        if (cap_reg > lkcd_pkg::CAP_W'(N))
            cap_eff = lkcd_pkg::CAP_W'(N);
        else
            cap_eff = cap_reg;
        oldest = SW'(count_reg - CW'(1));
        hit_c = '0;
        victim_c = '0;
        free_c = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            match_c[i] = valid_reg[i] && (tag_reg[i] == key_reg);
            if (match_c[i])
                hit_c = SW'(i);
            if (valid_reg[i] && rank_reg[i] == oldest)
                victim_c = SW'(i);
            if (!valid_reg[i])
                free_c = SW'(i);
        end
        old_rank = rank_reg[hit_slot_reg];
    end

    assign status.hit = hit_reg;
    assign status.hit_slot = hit_slot_reg;
    assign status.victim_slot = victim_reg;
    assign status.free_slot = free_reg;
    assign status.must_evict = (count_reg != '0) &&
                               ({1'b0, count_reg} >= {1'b0, cap_eff});
    assign status.cap_zero = (cap_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            cap_reg <= lkcd_pkg::CAP_W'(N);
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (cmd.evict)
            begin
                valid_reg[victim_reg] <= 1'b0;
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.insert)
            begin
                valid_reg[free_reg] <= 1'b1;
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            key_reg <= key_in;
        if (cmd.lookup)
        begin
            hit_reg <= |match_c;
            hit_slot_reg <= hit_c;
        end
        // victim and free slot follow the store every cycle
        victim_reg <= victim_c;
        free_reg <= free_c;
        for (int i = 0; i < N; i++)
        begin
            if (cmd.touch)
            begin
                if (SW'(i) == hit_slot_reg)
                    rank_reg[i] <= '0;
                else if (valid_reg[i] && rank_reg[i] < old_rank)
                    rank_reg[i] <= rank_reg[i] + SW'(1);
            end
            if (cmd.insert)
            begin
                if (SW'(i) == free_reg)
                begin
                    rank_reg[i] <= '0;
                    tag_reg[i] <= key_reg;
                end
                else if (valid_reg[i])
                    rank_reg[i] <= rank_reg[i] + SW'(1);
            end
        end
    end
endmodule

// File: hdl/lkcd_ctrl.sv
// Request sequencer: lookup, eviction loop, insertion and result register.
// Depends on lkcd_pkg.
module lkcd_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_bypass,
    output logic req_ready,
    output logic res_valid,
    input  logic res_ready,
    output logic [1:0] res_kind,
    output logic [4:0] res_slot,
    output logic res_last,
    input  lkcd_pkg::status_t status,
    output lkcd_pkg::cmd_t cmd
);
    lkcd_pkg::state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [4:0] slot_reg, slot_next;
    logic last_reg, last_next;
    logic settle_reg, settle_next;

    assign res_valid = (state_reg == lkcd_pkg::ST_OUT);
    assign res_kind = kind_reg;
    assign res_slot = slot_reg;
    assign res_last = last_reg;
    assign req_ready = (state_reg == lkcd_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkcd_pkg::ST_IDLE;
            settle_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            settle_reg <= settle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        slot_reg <= slot_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        slot_next = slot_reg;
        last_next = last_reg;
        settle_next = 1'b0;
        cmd = '0;
        unique case (state_reg)
            lkcd_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_bypass || status.cap_zero)
                    begin
                        kind_next = lkcd_pkg::KIND_BYPASS;
                        slot_next = '0;
                        last_next = 1'b1;
                        state_next = lkcd_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        state_next = lkcd_pkg::ST_LOOKUP;
                    end
                end
            end
            lkcd_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = lkcd_pkg::ST_EVICT;
                settle_next = 1'b1;
            end
            lkcd_pkg::ST_EVICT:
            begin
                // settle: registered victim/free slots lag the store
                if (!settle_reg)
                    settle_next = 1'b1;
                else if (status.hit)
                begin
                    cmd.touch = 1'b1;
                    kind_next = lkcd_pkg::KIND_HIT;
                    slot_next = status.hit_slot;
                    last_next = 1'b1;
                    state_next = lkcd_pkg::ST_OUT;
                end
                else if (status.must_evict)
                begin
                    cmd.evict = 1'b1;
                    kind_next = lkcd_pkg::KIND_EVICT;
                    slot_next = status.victim_slot;
                    last_next = 1'b0;
                    state_next = lkcd_pkg::ST_OUT;
                end
                else
                    state_next = lkcd_pkg::ST_INSERT;
            end
            lkcd_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                kind_next = lkcd_pkg::KIND_INSERT;
                slot_next = status.free_slot;
                last_next = 1'b1;
                state_next = lkcd_pkg::ST_OUT;
            end
            lkcd_pkg::ST_OUT:
            begin
                if (res_ready)
                begin
                    if (last_reg)
                        state_next = lkcd_pkg::ST_IDLE;
                    else
                        state_next = lkcd_pkg::ST_EVICT;
                end
            end
            default: state_next = lkcd_pkg::ST_IDLE;
        endcase
    end
endmodule

// File: hdl/lru_key_cache_directory_unit.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | key_word0..3, bypass
// res     | out | valid/ready | kind, slot, last
// cfg     | in  | valid/ready | data (capacity)
// A bypass goes straight to its result; a hit passes the lookup and evict states; a miss
// also passes insertion, after the eviction loop in the controller frees one slot each pass.
// Reset clears valid bits, count and capacity to 32 at once; no clearing pass.
// A stalled result holds its state until taken; no request is accepted meanwhile.
// Depends on lkcd_pkg, lkcd_if, lkcd_ctrl and lkcd_datapath.
module lru_key_cache_directory_unit (
    input logic clk,
    input logic rst_n,
    lkcd_req_if.sink req,
    lkcd_res_if.source res,
    lkcd_cfg_if.sink cfg
);
    lkcd_pkg::cmd_t cmd;
    lkcd_pkg::status_t status;

    assign cfg.ready = 1'b1;

    lkcd_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req.valid),
        .req_bypass(req.bypass),
        .req_ready(req.ready),
        .res_valid(res.valid),
        .res_ready(res.ready),
        .res_kind(res.kind),
        .res_slot(res.slot),
        .res_last(res.last),
        .status(status),
        .cmd(cmd)
    );

    lkcd_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .key_in({req.key_word3, req.key_word2, req.key_word1, req.key_word0}),
        .cfg_we(cfg.valid),
        .cfg_data(cfg.data),
        .status(status)
    );
endmodule

// File: hdl/lkcd_checker.sv
// Port-level checks for the LRU key cache directory, bound to the top level.
// Depends on lkcd_pkg.
module lkcd_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input logic [1:0] res_kind,
    input logic [4:0] res_slot,
    input logic res_last
);
    a_no_req_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req_ready) else $error("request taken with result pending");
    a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == lkcd_pkg::KIND_EVICT |-> !res_last)
        else $error("eviction marked last");
    a_bypass_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == lkcd_pkg::KIND_BYPASS |-> res_slot == 5'd0 && res_last)
        else $error("bad bypass result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_slot))
        else $error("stalled result changed");
endmodule

bind lru_key_cache_directory_unit lkcd_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .res_valid(res.valid), .res_ready(res.ready),
    .res_kind(res.kind), .res_slot(res.slot), .res_last(res.last)
);

// File: bench/tb.sv
// Self-checking bench for lru_key_cache_directory_unit: random and directed
// requests against an LRU directory predictor. Depends on lkcd_pkg and lkcd_if.
module tb;
    typedef struct packed {
        logic [63:0] w0, w1, w2, w3;
        logic        bypass;
    } request_t;

    typedef struct packed {
        lkcd_pkg::kind_t kind;
        logic [4:0]      slot;
        logic            last;
    } outcome_t;

    logic clk;
    logic rst_n;

    lkcd_req_if req ();
    lkcd_res_if res ();
    lkcd_cfg_if cfg ();

    lru_key_cache_directory_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .res(res),
        .cfg(cfg)
    );

    // predictor state
    logic        slot_used [lkcd_pkg::ENTRIES] = '{default: 1'b0};
    logic [63:0] tag0 [lkcd_pkg::ENTRIES], tag1 [lkcd_pkg::ENTRIES];
    logic [63:0] tag2 [lkcd_pkg::ENTRIES], tag3 [lkcd_pkg::ENTRIES];
    int          rank [lkcd_pkg::ENTRIES] = '{default: 0};
    int          used_count = 0;
    int          cap_setting = 32;

    request_t pending_requests [$];
    outcome_t expected_outcomes [$];
    request_t key_pool [$];

    int mismatches = 0;
    int outcomes_seen = 0;
    int requests_sent = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    localparam int WATCHDOG = 20000;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic add_expected(input lkcd_pkg::kind_t k, input logic [4:0] s,
                                input logic l);
        outcome_t o;
        o.kind = k;
        o.slot = s;
        o.last = l;
        expected_outcomes = {expected_outcomes, o};
    endtask

    task automatic enqueue_request(input request_t q);
        pending_requests = {pending_requests, q};
    endtask

    task automatic predict_request(input request_t q);
        int cap;
        int hit;
        int victim;
        int freeslot;
        int r;
        cap = (cap_setting > lkcd_pkg::ENTRIES) ? lkcd_pkg::ENTRIES : cap_setting;
        if (q.bypass || cap == 0)
        begin
            add_expected(lkcd_pkg::KIND_BYPASS, 5'd0, 1'b1);
            return;
        end
        hit = -1;
        for (int i = 0; i < lkcd_pkg::ENTRIES; i++)
            if (hit < 0 && slot_used[i] && tag0[i] == q.w0 && tag1[i] == q.w1 &&
                tag2[i] == q.w2 && tag3[i] == q.w3)
                hit = i;
        if (hit >= 0)
        begin
            r = rank[hit];
            for (int i = 0; i < lkcd_pkg::ENTRIES; i++)
                if (slot_used[i] && rank[i] < r)
                    rank[i]++;
            rank[hit] = 0;
            add_expected(lkcd_pkg::KIND_HIT, 5'(hit), 1'b1);
            return;
        end
        while (used_count >= cap && used_count > 0)
        begin
            victim = -1;
            for (int j = 0; j < lkcd_pkg::ENTRIES; j++)
                if (victim < 0 && slot_used[j] && rank[j] == used_count - 1)
                    victim = j;
            slot_used[victim] = 1'b0;
            used_count--;
            add_expected(lkcd_pkg::KIND_EVICT, 5'(victim), 1'b0);
        end
        freeslot = -1;
        for (int i = 0; i < lkcd_pkg::ENTRIES; i++)
            if (freeslot < 0 && !slot_used[i])
                freeslot = i;
        for (int j = 0; j < lkcd_pkg::ENTRIES; j++)
            if (slot_used[j])
                rank[j]++;
        slot_used[freeslot] = 1'b1;
        tag0[freeslot] = q.w0;
        tag1[freeslot] = q.w1;
        tag2[freeslot] = q.w2;
        tag3[freeslot] = q.w3;
        rank[freeslot] = 0;
        used_count++;
        add_expected(lkcd_pkg::KIND_INSERT, 5'(freeslot), 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // request driver; hold a request until the monitor has counted it
    int req_gap;
    int drive_count;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.key_word0 <= '0;
            req.key_word1 <= '0;
            req.key_word2 <= '0;
            req.key_word3 <= '0;
            req.bypass <= 1'b0;
            req_gap = 0;
            drive_count = 0;
        end
        else if (req.valid && requests_sent == drive_count)
        begin
            // hold
        end
        else if (req_gap > 0)
        begin
            req.valid <= 1'b0;
            req_gap--;
        end
        else if (pending_requests.size() > 0)
        begin
            request_t q;
            q = pending_requests.pop_front();
            req.key_word0 <= q.w0;
            req.key_word1 <= q.w1;
            req.key_word2 <= q.w2;
            req.key_word3 <= q.w3;
            req.bypass <= q.bypass;
            req.valid <= 1'b1;
            drive_count = requests_sent;
            req_gap = gap_len();
        end
        else
            req.valid <= 1'b0;
    end

    // result ready with random stalls
    int res_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            res_gap = 0;
        end
        else if (res_gap > 0)
        begin
            res.ready <= 1'b0;
            res_gap--;
        end
        else
        begin
            res.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                res_gap = gap_len();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (req.valid && req.ready)
            begin
                request_t q;
                q = '{req.key_word0, req.key_word1, req.key_word2, req.key_word3,
                      req.bypass};
                predict_request(q);
                requests_sent++;
                idle_cycles = 0;
            end
            if (cfg.valid && cfg.ready)
            begin
                cap_setting = int'(cfg.data);
                idle_cycles = 0;
            end
            if (res.valid && res.ready)
            begin
                outcome_t e;
                idle_cycles = 0;
                outcomes_seen++;
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d slot=%0d last=%0b",
                                 res.kind, res.slot, res.last);
                end
                else
                begin
                    e = expected_outcomes.pop_front();
                    if (res.kind !== e.kind || res.slot !== e.slot ||
                        res.last !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     e.kind, e.slot, e.last,
                                     res.kind, res.slot, res.last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding",
                     expected_outcomes.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic request_t random_key();
        request_t q;
        int mode;
        mode = $urandom_range(0, 9);
        q.w0 = {$urandom, $urandom};
        q.w1 = {$urandom, $urandom};
        q.w2 = {$urandom, $urandom};
        q.w3 = {$urandom, $urandom};
        if (mode == 0)
            q = {{4{64'hFFFF_FFFF_FFFF_FFFF}}, 1'b0};
        else if (mode == 1)
            q = '0;
        q.bypass = 1'b0;
        return q;
    endfunction

    // queue a request drawn mostly from a small pool so hits are common
    task automatic queue_mixed_request(input int pool_size);
        request_t q;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            q = random_key();
            q.bypass = 1'b1;
        end
        else if (r < 70 && key_pool.size() > 0)
            q = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
        begin
            q = random_key();
            key_pool = {key_pool, q};
            if (key_pool.size() > pool_size)
                void'(key_pool.pop_front());
        end
        enqueue_request(q);
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || req.valid ||
               expected_outcomes.size() > 0)
            @(posedge clk);
        // hold for the longest eviction sweep
        repeat (120) @(posedge clk);
    endtask

    task automatic write_capacity(input int value);
        @(negedge clk);
        cfg.data <= 6'(value);
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    request_t d;
    int caps [6] = '{32, 3, 0, 63, 1, 17};

    initial
    begin
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, bypass on empty store, partial fill, hit
        enqueue_request('{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                          1'b1});
        enqueue_request('{64'h0, 64'h0, 64'h0, 64'h0, 1'b0});
        enqueue_request('{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                          1'b0});
        enqueue_request('{64'h0, 64'h0, 64'h0, 64'h0, 1'b0});
        enqueue_request('{64'h0, 64'h0, 64'h0, 64'h1, 1'b0});
        for (int i = 0; i < 16; i++)
        begin
            d = random_key();
            enqueue_request(d);
        end
        drain();

        // fill then lower capacity below count: next miss sweeps many evictions
        write_capacity(32);
        for (int i = 0; i < 40; i++)
        begin
            d = random_key();
            d.w0[7:0] = 8'(i);
            enqueue_request(d);
        end
        drain();
        write_capacity(1);
        enqueue_request('{64'h0, 64'h0, 64'h0, 64'h0, 1'b1});
        d = random_key();
        enqueue_request(d);
        enqueue_request(d);
        drain();

        // random phases across capacities
        for (int p = 0; p < 6; p++)
        begin
            write_capacity(caps[p]);
            key_pool.delete();
            for (int i = 0; i < 70; i++)
                queue_mixed_request((caps[p] == 0) ? 4 : caps[p] + 4);
            drain();
        end

        $display("sent %0d requests, checked %0d results over capacities 0..63",
                 requests_sent, outcomes_seen);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule
